### src/ffa_pkg.sv
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps
package ffa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 20;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OFF_W      = ADDR_BITS;
    localparam int SIZE_W     = ADDR_BITS + 1;
    localparam int OP_W       = 2;
    localparam int ST_W       = 3;

    localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_BITS;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_SIZE  = 3'd4;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{off: '0, size: POOL_MAX, free: 1'b1};

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INIT,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        t_entry           data;
    } t_cell_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OFF_W-1:0] result_offset;
        logic             moved;
    } t_rsp;

endpackage

### src/ffa_req_if.sv
// Request channel interface.
`timescale 1ns / 1ps
interface ffa_req_if import ffa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  req_offset;

    modport source (output valid, output op, output req_size, output req_offset, input ready);
    modport sink (input valid, input op, input req_size, input req_offset, output ready);
endinterface

### src/ffa_rsp_if.sv
// Response channel interface.
`timescale 1ns / 1ps
interface ffa_rsp_if import ffa_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] result_offset;
    logic             moved;

    modport source (output valid, output status, output result_offset, output moved,
                    input ready);
    modport sink (input valid, input status, input result_offset, input moved,
                  output ready);
endinterface

### src/ffa_cfg_if.sv
// Configuration write channel interface.
`timescale 1ns / 1ps
interface ffa_cfg_if import ffa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] pool_size;

    modport source (output valid, output pool_size, input ready);
    modport sink (input valid, input pool_size, output ready);
endinterface

### src/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer and cell row.
// One transaction at a time; each table change is one command on the cell row.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous active low; table holds one free block of 1048576 bytes, count 1.
// A pool_size write reinitializes the table.
`timescale 1ns / 1ps
module first_fit_block_allocator import ffa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp,
    ffa_cfg_if.sink   i_cfg
);

    t_cell_cmd w_cmd;
    t_entry    w_ent [MAX_BLOCKS];

    ffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_ent   (w_ent),
        .o_cmd   (w_cmd)
    );

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_ent[g-1];
        end

        if (g == MAX_BLOCKS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_ent[g+1];
        end

        ffa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_ent[g])
        );
    end

endmodule

### src/ffa_cell.sv
// One table cell: holds one block entry and moves it to or from its neighbors.
`timescale 1ns / 1ps
module ffa_cell import ffa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_cmd        i_cmd,
    input  t_entry           i_prev,
    input  t_entry           i_next,
    output t_entry           o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            CELL_HOLD: begin
            end
            CELL_WRITE: begin
                if (i_index == i_cmd.pos) n_entry = i_cmd.data;
            end
            CELL_INIT: begin
                if (i_index == '0) n_entry = i_cmd.data;
            end
            CELL_SHIFT_UP: begin
                if (i_index > i_cmd.pos) n_entry = i_prev;
            end
            CELL_SHIFT_DOWN: begin
                if (i_index >= i_cmd.pos) n_entry = i_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n && i_index == '0) begin
            r_entry <= RESET_ENTRY;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### src/ffa_ctrl.sv
// Sequencer: search over the cell row, split, merge and relocate planning.
`timescale 1ns / 1ps
module ffa_ctrl import ffa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffa_req_if.sink     i_req,
    ffa_rsp_if.source   o_rsp,
    ffa_cfg_if.sink     i_cfg,
    input  t_entry      i_ent [MAX_BLOCKS],
    output t_cell_cmd   o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_FIND   = 13'b0000000000010,
        S_DECIDE = 13'b0000000000100,
        S_INS    = 13'b0000000001000,
        S_W1     = 13'b0000000010000,
        S_W0     = 13'b0000000100000,
        S_CLOSE  = 13'b0000001000000,
        S_RFIND  = 13'b0000010000000,
        S_RCUR   = 13'b0000100000000,
        S_RCLNX  = 13'b0001000000000,
        S_RPREV  = 13'b0010000000000,
        S_RCLCUR = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [OP_W-1:0]   r_op, n_op;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_hit, n_hit;
    logic              r_fit, n_fit;
    logic              r_reloc, n_reloc;
    logic              r_w1f, n_w1f;
    logic              r_close, n_close;
    t_entry            r_w1, n_w1;
    t_entry            r_w0, n_w0;
    logic [ST_W-1:0]   r_status, n_status;
    logic [OFF_W-1:0]  r_res, n_res;
    logic              r_moved, n_moved;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    logic [MAX_BLOCKS-1:0] w_match;
    logic                  w_fit_mode;
    logic [IDX_W-1:0]      f_idx;
    logic                  f_hit;
    logic [IDX_W-1:0]      w_idx_n;
    logic [IDX_W-1:0]      w_idx_p;
    t_entry                e_i, e_n, e_p;
    logic                  w_n_valid;
    logic                  w_full;
    logic [SIZE_W-1:0]     w_rem;
    logic [SIZE_W-1:0]     w_total;
    logic [SIZE_W-1:0]     w_cfg_size;

    assign w_fit_mode = r_fit && (r_state == S_FIND);

    always_comb begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (w_fit_mode) begin
                w_match[i] = (CNT_W'(i) < r_count) && i_ent[i].free
                             && (i_ent[i].size >= r_size);
            end else begin
                w_match[i] = (CNT_W'(i) < r_count) && !i_ent[i].free
                             && (i_ent[i].off == r_off);
            end
        end
    end

    always_comb begin
        f_idx = '0;
        f_hit = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                f_idx = IDX_W'(i);
                f_hit = 1'b1;
            end
        end
    end

    assign w_idx_n   = r_idx + IDX_W'(1);
    assign w_idx_p   = r_idx - IDX_W'(1);
    assign e_i       = i_ent[r_idx];
    assign e_n       = i_ent[w_idx_n];
    assign e_p       = i_ent[w_idx_p];
    assign w_n_valid = ({1'b0, r_idx} + CNT_W'(1)) < r_count;
    assign w_full    = r_count >= CNT_W'(MAX_BLOCKS);
    assign w_rem     = e_i.size - r_size;
    assign w_total   = e_i.size + e_n.size;

    always_comb begin
        w_cfg_size = i_cfg.pool_size;
        if (i_cfg.pool_size == '0) begin
            w_cfg_size = SIZE_W'(1);
        end else if (i_cfg.pool_size > POOL_MAX) begin
            w_cfg_size = POOL_MAX;
        end
    end

    assign i_req.ready = i_rst_n && (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_size      = r_size;
        n_off       = r_off;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_fit       = r_fit;
        n_reloc     = r_reloc;
        n_w1f       = r_w1f;
        n_close     = r_close;
        n_w1        = r_w1;
        n_w0        = r_w0;
        n_status    = r_status;
        n_res       = r_res;
        n_moved     = r_moved;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        o_cmd       = '{op: CELL_HOLD, pos: '0, data: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg.valid) begin
                    o_cmd.op        = CELL_INIT;
                    o_cmd.data.size = w_cfg_size;
                    o_cmd.data.free = 1'b1;
                    n_count         = CNT_W'(1);
                end else if (i_req.valid) begin
                    n_op     = i_req.op;
                    n_size   = i_req.req_size;
                    n_off    = i_req.req_offset;
                    n_fit    = (i_req.op == OP_ALLOC);
                    n_reloc  = 1'b0;
                    n_w1f    = 1'b0;
                    n_close  = 1'b0;
                    n_status = ST_OK;
                    n_res    = '0;
                    n_moved  = 1'b0;
                    if (i_req.op == OP_FREE) begin
                        n_state = S_FIND;
                    end else if ((i_req.op == OP_ALLOC || i_req.op == OP_RESIZE)
                                 && i_req.req_size != '0) begin
                        n_state = S_FIND;
                    end else begin
                        n_status = ST_BAD_SIZE;
                        n_state  = S_DONE;
                    end
                end
            end
            S_FIND: begin
                n_idx   = f_idx;
                n_hit   = f_hit;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_w1f   = 1'b0;
                n_close = 1'b0;
                n_w0    = '{off: e_i.off, size: r_size, free: 1'b0};
                if (r_fit) begin
                    if (!r_hit) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_DONE;
                    end else if (e_i.size == r_size) begin
                        n_res   = e_i.off;
                        n_moved = r_reloc;
                        n_state = S_W0;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_w1f   = 1'b1;
                        n_w1    = '{off: e_i.off + r_size[OFF_W-1:0], size: w_rem,
                                    free: 1'b1};
                        n_res   = e_i.off;
                        n_moved = r_reloc;
                        n_state = S_INS;
                    end
                end else if (!r_hit) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (r_op == OP_FREE) begin
                    n_state = S_RCUR;
                end else begin
                    n_res = r_off;
                    if (r_size == e_i.size) begin
                        n_state = S_DONE;
                    end else if (r_size < e_i.size) begin
                        if (w_n_valid && e_n.free) begin
                            n_w1f   = 1'b1;
                            n_w1    = '{off: e_n.off - (e_i.size[OFF_W-1:0]
                                        - r_size[OFF_W-1:0]),
                                        size: e_n.size + (e_i.size - r_size), free: 1'b1};
                            n_state = S_W1;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                            n_res    = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_w1f   = 1'b1;
                            n_w1    = '{off: r_off + r_size[OFF_W-1:0],
                                        size: e_i.size - r_size, free: 1'b1};
                            n_state = S_INS;
                        end
                    end else if (w_n_valid && e_n.free && w_total >= r_size) begin
                        if (w_total == r_size) begin
                            n_close = 1'b1;
                        end else begin
                            n_w1f = 1'b1;
                            n_w1  = '{off: r_off + r_size[OFF_W-1:0],
                                      size: w_total - r_size, free: 1'b1};
                        end
                        n_state = (w_total == r_size) ? S_W0 : S_W1;
                    end else begin
                        n_res   = '0;
                        n_fit   = 1'b1;
                        n_reloc = 1'b1;
                        n_state = S_FIND;
                    end
                end
            end
            S_INS: begin
                o_cmd.op  = CELL_SHIFT_UP;
                o_cmd.pos = w_idx_n;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_W1;
            end
            S_W1: begin
                o_cmd.op   = CELL_WRITE;
                o_cmd.pos  = w_idx_n;
                o_cmd.data = r_w1;
                n_state    = S_W0;
            end
            S_W0: begin
                o_cmd.op   = CELL_WRITE;
                o_cmd.pos  = r_idx;
                o_cmd.data = r_w0;
                if (r_close) begin
                    n_state = S_CLOSE;
                end else if (r_reloc) begin
                    n_state = S_RFIND;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLOSE: begin
                o_cmd.op  = CELL_SHIFT_DOWN;
                o_cmd.pos = w_idx_n;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_DONE;
            end
            S_RFIND: begin
                n_idx   = f_idx;
                n_hit   = f_hit;
                n_state = S_RCUR;
            end
            S_RCUR: begin
                if (!r_hit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op   = CELL_WRITE;
                    o_cmd.pos  = r_idx;
                    o_cmd.data = '{off: e_i.off,
                                   size: (w_n_valid && e_n.free) ? w_total : e_i.size,
                                   free: 1'b1};
                    n_state    = (w_n_valid && e_n.free) ? S_RCLNX : S_RPREV;
                end
            end
            S_RCLNX: begin
                o_cmd.op  = CELL_SHIFT_DOWN;
                o_cmd.pos = w_idx_n;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_RPREV;
            end
            S_RPREV: begin
                if (r_idx != '0 && e_p.free) begin
                    o_cmd.op   = CELL_WRITE;
                    o_cmd.pos  = w_idx_p;
                    o_cmd.data = '{off: e_p.off, size: e_p.size + e_i.size, free: 1'b1};
                    n_state    = S_RCLCUR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RCLCUR: begin
                o_cmd.op  = CELL_SHIFT_DOWN;
                o_cmd.pos = r_idx;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid = 1'b1;
                    n_rsp       = '{status: r_status, result_offset: r_res,
                                    moved: r_moved};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_hit       <= 1'b0;
            r_fit       <= 1'b0;
            r_reloc     <= 1'b0;
            r_w1f       <= 1'b0;
            r_close     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hit       <= n_hit;
            r_fit       <= n_fit;
            r_reloc     <= n_reloc;
            r_w1f       <= n_w1f;
            r_close     <= n_close;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_size   <= n_size;
        r_off    <= n_off;
        r_idx    <= n_idx;
        r_w1     <= n_w1;
        r_w0     <= n_w0;
        r_status <= n_status;
        r_res    <= n_res;
        r_moved  <= n_moved;
        r_rsp    <= n_rsp;
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.result_offset = r_rsp.result_offset;
    assign o_rsp.moved         = r_rsp.moved;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CNT_W'(MAX_BLOCKS))
        else $error("entry count out of range");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |-> !w_full)
        else $error("insert with full table");

    a_ins_then_w1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |=> r_state == S_W1 && r_w1f)
        else $error("insert not followed by neighbor write");

    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.moved |-> r_rsp.status == ST_OK)
        else $error("moved flag on failed transaction");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && (!r_rsp_valid || o_rsp.ready) |=> r_state == S_IDLE && r_rsp_valid)
        else $error("result not posted");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for the first-fit block allocator: directed table plus random traffic.
`timescale 1ns / 1ps
module tb;
    import ffa_pkg::*;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
        bit                typed;
        t_rsp              rsp;
    } t_row;

    localparam int NUM_PHASES    = 7;
    localparam int ITEMS_PER_PH  = 123;
    localparam int LONG_HOLD     = 400;
    localparam int WATCHDOG_MAX  = 3000;
    localparam logic [OP_W-1:0] OP_BAD = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffa_req_if req_if ();
    ffa_rsp_if rsp_if ();
    ffa_cfg_if cfg_if ();

    first_fit_block_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [OFF_W-1:0]  blk_off  [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
    bit                blk_free [MAX_BLOCKS];
    int                blk_cnt;
    int                pool_bytes;

    t_rsp rsp_q [$];
    int   mismatches = 0;
    int   activity = 0;
    bit   quiet = 1'b0;
    bit   hold_long = 1'b0;

    function automatic void init_pool(int bytes);
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            blk_off[k] = '0;
            blk_size[k] = '0;
            blk_free[k] = 1'b0;
        end
        pool_bytes = bytes;
        blk_cnt = 1;
        blk_size[0] = SIZE_W'(bytes);
        blk_free[0] = 1'b1;
    endfunction

    function automatic void open_at(int pos);
        for (int k = blk_cnt; k > pos; k--) begin
            blk_off[k] = blk_off[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
        end
        blk_cnt++;
    endfunction

    function automatic void close_at(int pos);
        for (int k = pos; k + 1 < blk_cnt; k++) begin
            blk_off[k] = blk_off[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_cnt--;
    endfunction

    function automatic int find_used(int off);
        for (int k = 0; k < blk_cnt; k++)
            if (!blk_free[k] && int'(blk_off[k]) == off) return k;
        return blk_cnt;
    endfunction

    function automatic logic [ST_W-1:0] take_first_fit(int size, output int off);
        off = 0;
        for (int k = 0; k < blk_cnt; k++) begin
            if (!blk_free[k] || int'(blk_size[k]) < size) continue;
            if (int'(blk_size[k]) == size) begin
                blk_free[k] = 1'b0;
                off = blk_off[k];
                return ST_OK;
            end
            if (blk_cnt >= MAX_BLOCKS) return ST_FULL;
            open_at(k + 1);
            blk_off[k+1] = OFF_W'(int'(blk_off[k]) + size);
            blk_size[k+1] = SIZE_W'(int'(blk_size[k]) - size);
            blk_free[k+1] = 1'b1;
            blk_size[k] = SIZE_W'(size);
            blk_free[k] = 1'b0;
            off = blk_off[k];
            return ST_OK;
        end
        return ST_NO_SPACE;
    endfunction

    function automatic void release_blk(int k);
        blk_free[k] = 1'b1;
        if (k + 1 < blk_cnt && blk_free[k+1]) begin
            blk_size[k] = blk_size[k] + blk_size[k+1];
            close_at(k + 1);
        end
        if (k > 0 && blk_free[k-1]) begin
            blk_size[k-1] = blk_size[k-1] + blk_size[k];
            close_at(k);
        end
    endfunction

    function automatic logic [ST_W-1:0] resize_blk(int off, int size, output int res,
                                                   output bit mv);
        int k;
        int cur;
        int rem;
        int total;
        int noff;
        logic [ST_W-1:0] st;
        res = 0;
        mv = 1'b0;
        k = find_used(off);
        if (k >= blk_cnt) return ST_NOT_FOUND;
        cur = blk_size[k];
        res = off;
        if (size == cur) return ST_OK;
        if (size < cur) begin
            rem = cur - size;
            if (k + 1 < blk_cnt && blk_free[k+1]) begin
                blk_off[k+1] = OFF_W'(int'(blk_off[k+1]) - rem);
                blk_size[k+1] = SIZE_W'(int'(blk_size[k+1]) + rem);
            end else begin
                if (blk_cnt >= MAX_BLOCKS) return ST_FULL;
                open_at(k + 1);
                blk_off[k+1] = OFF_W'(off + size);
                blk_size[k+1] = SIZE_W'(rem);
                blk_free[k+1] = 1'b1;
            end
            blk_size[k] = SIZE_W'(size);
            return ST_OK;
        end
        if (k + 1 < blk_cnt && blk_free[k+1] && cur + int'(blk_size[k+1]) >= size) begin
            total = cur + int'(blk_size[k+1]);
            if (total == size) begin
                close_at(k + 1);
            end else begin
                blk_off[k+1] = OFF_W'(off + size);
                blk_size[k+1] = SIZE_W'(total - size);
            end
            blk_size[k] = SIZE_W'(size);
            return ST_OK;
        end
        st = take_first_fit(size, noff);
        if (st != ST_OK) begin
            res = 0;
            return st;
        end
        k = find_used(off);
        if (k < blk_cnt) release_blk(k);
        res = noff;
        mv = 1'b1;
        return ST_OK;
    endfunction

    function automatic t_rsp predict_alloc(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                           logic [OFF_W-1:0] off);
        t_rsp r;
        int res;
        int k;
        bit mv;
        r = '0;
        res = 0;
        mv = 1'b0;
        if (op == OP_ALLOC) begin
            r.status = (size == 0) ? ST_BAD_SIZE : take_first_fit(int'(size), res);
        end else if (op == OP_FREE) begin
            k = find_used(int'(off));
            if (k >= blk_cnt) begin
                r.status = ST_NOT_FOUND;
            end else begin
                release_blk(k);
                r.status = ST_OK;
            end
        end else if (op == OP_RESIZE) begin
            r.status = (size == 0) ? ST_BAD_SIZE : resize_blk(int'(off), int'(size), res, mv);
        end else begin
            r.status = ST_BAD_SIZE;
        end
        if (r.status == ST_OK) begin
            r.result_offset = OFF_W'(res);
            r.moved = mv;
        end
        return r;
    endfunction

    function automatic int pick_used();
        int idx [$];
        for (int k = 0; k < blk_cnt; k++)
            if (!blk_free[k]) idx.push_back(k);
        if (idx.size() == 0) return -1;
        return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    function automatic int pick_free_size();
        int sz [$];
        for (int k = 0; k < blk_cnt; k++)
            if (blk_free[k]) sz.push_back(blk_size[k]);
        if (sz.size() == 0) return 1;
        return sz[$urandom_range(0, sz.size() - 1)];
    endfunction

    function automatic void make_item(output logic [OP_W-1:0] op,
                                      output logic [SIZE_W-1:0] size,
                                      output logic [OFF_W-1:0] off);
        int r;
        int k;
        int cap;
        int cur;
        r = $urandom_range(0, 99);
        k = pick_used();
        cap = (pool_bytes / 8 < 1) ? 1 : pool_bytes / 8;
        op = OP_ALLOC;
        size = SIZE_W'($urandom_range(1, 64));
        off = OFF_W'($urandom);
        if (r < 45) begin
            case ($urandom_range(0, 3))
                0: size = SIZE_W'($urandom_range(1, cap));
                1: size = SIZE_W'(pick_free_size());
                2: size = SIZE_W'($urandom_range(1, 64));
                default: size = SIZE_W'($urandom_range(1, pool_bytes));
            endcase
        end else if (r < 72) begin
            op = OP_FREE;
            if (k >= 0 && $urandom_range(0, 9) != 0) off = blk_off[k];
        end else if (r < 92) begin
            op = OP_RESIZE;
            if (k >= 0 && $urandom_range(0, 9) != 0) begin
                off = blk_off[k];
                cur = blk_size[k];
                case ($urandom_range(0, 3))
                    0: size = SIZE_W'($urandom_range(1, cur));
                    1: size = SIZE_W'(cur + ((k + 1 < blk_cnt && blk_free[k+1]) ?
                                              $urandom_range(1, blk_size[k+1]) : 1));
                    2: size = SIZE_W'(cur + $urandom_range(1, cap));
                    default: size = SIZE_W'($urandom_range(1, cap));
                endcase
            end
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    op = OP_BAD;
                    size = SIZE_W'($urandom);
                end
                1: size = '0;
                2: begin
                    op = OP_RESIZE;
                    size = '0;
                    if (k >= 0) off = blk_off[k];
                end
                3: size = SIZE_W'($urandom);
                default: op = OP_FREE;
            endcase
        end
    endfunction

    task automatic send_req(t_row row);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op <= row.op;
        req_if.req_size <= row.size;
        req_if.req_offset <= row.off;
        forever begin
            @(negedge i_clk);
            if (req_if.ready) break;
        end
        if (row.typed) begin
            void'(predict_alloc(row.op, row.size, row.off));
            rsp_q.push_back(row.rsp);
        end else begin
            rsp_q.push_back(predict_alloc(row.op, row.size, row.off));
        end
        activity++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_pool(logic [SIZE_W-1:0] value);
        int v;
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.pool_size <= value;
        forever begin
            @(negedge i_clk);
            if (cfg_if.ready) break;
        end
        activity++;
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        v = int'(value);
        if (v < 1) v = 1;
        if (v > int'(POOL_MAX)) v = int'(POOL_MAX);
        init_pool(v);
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                hold_long = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            activity++;
            if (rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: status %0d offset %0h moved %0b",
                             rsp_if.status, rsp_if.result_offset, rsp_if.moved);
            end else begin
                want = rsp_q.pop_front();
                if (rsp_if.status !== want.status || rsp_if.result_offset !== want.result_offset
                        || rsp_if.moved !== want.moved) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0h/%0b, actual %0d/%0h/%0b",
                                 want.status, want.result_offset, want.moved,
                                 rsp_if.status, rsp_if.result_offset, rsp_if.moved);
                end
            end
        end
    end

    initial begin
        int last;
        int still;
        last = 0;
        still = 0;
        forever begin
            @(posedge i_clk);
            if (activity != last) begin
                last = activity;
                still = 0;
            end else if (++still >= WATCHDOG_MAX) begin
                $display("FAIL first_fit_block_allocator");
                $finish;
            end
        end
    end

    initial begin
        t_row dir [$];
        t_row row;
        logic [SIZE_W-1:0] pools [NUM_PHASES];
        pools = '{21'd1048576, 21'd1, 21'd0, 21'h1FFFFF, 21'd4096, 21'd100, 21'd1048576};

        dir = '{
            '{OP_ALLOC,  21'd0,       20'd0,     1'b1, '{ST_BAD_SIZE, 20'd0, 1'b0}},
            '{OP_BAD,    21'h1FFFFF,  20'hFFFFF, 1'b1, '{ST_BAD_SIZE, 20'd0, 1'b0}},
            '{OP_ALLOC,  21'd1048576, 20'd0,     1'b1, '{ST_OK,       20'd0, 1'b0}},
            '{OP_ALLOC,  21'd1,       20'd0,     1'b1, '{ST_NO_SPACE, 20'd0, 1'b0}},
            '{OP_FREE,   21'd0,       20'd5,     1'b1, '{ST_NOT_FOUND, 20'd0, 1'b0}},
            '{OP_FREE,   21'd0,       20'd0,     1'b1, '{ST_OK,       20'd0, 1'b0}},
            '{OP_FREE,   21'd0,       20'd0,     1'b1, '{ST_NOT_FOUND, 20'd0, 1'b0}},
            '{OP_ALLOC,  21'h1FFFFF,  20'd0,     1'b1, '{ST_NO_SPACE, 20'd0, 1'b0}},
            '{OP_ALLOC,  21'd16,      20'd0,     1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_ALLOC,  21'd32,      20'd0,     1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd8,       20'd0,     1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd16,      20'd16,    1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd20,      20'd0,     1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd0,       20'd16,    1'b1, '{ST_BAD_SIZE, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd4,       20'd1000,  1'b1, '{ST_NOT_FOUND, 20'd0, 1'b0}},
            '{OP_FREE,   21'd0,       20'hFFFFF, 1'b1, '{ST_NOT_FOUND, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd1048576, 20'd32,    1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd24,      20'd16,    1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_RESIZE, 21'd16,      20'd16,    1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_FREE,   21'd0,       20'd32,    1'b0, '{ST_OK, 20'd0, 1'b0}},
            '{OP_FREE,   21'd0,       20'd16,    1'b0, '{ST_OK, 20'd0, 1'b0}}
        };

        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.op <= OP_ALLOC;
        req_if.req_size <= '0;
        req_if.req_offset <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.pool_size <= '0;
        init_pool(int'(POOL_MAX));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[n]) send_req(dir[n]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) write_pool(pools[ph]);
            quiet = (ph == NUM_PHASES - 1);
            if (ph == 4) begin
                // fill the table with unit blocks until splits fail
                for (int n = 0; n < MAX_BLOCKS + 4; n++) begin
                    row = '{OP_ALLOC, 21'd1, 20'd0, 1'b0, '0};
                    send_req(row);
                end
            end
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                if (ph == 3 && n == 20) hold_long = 1'b1;
                if (ph == 5 && n == 30) begin
                    req_if.valid <= 1'b0;
                    while (rsp_q.size() != 0) @(posedge i_clk);
                end
                row.typed = 1'b0;
                row.rsp = '0;
                make_item(row.op, row.size, row.off);
                send_req(row);
            end
        end

        drain();
        if (mismatches == 0 && rsp_q.size() == 0) begin
            $display("PASS first_fit_block_allocator");
        end else begin
            $display("FAIL first_fit_block_allocator");
        end
        $finish;
    end

endmodule

### files.f
src/ffa_pkg.sv
src/ffa_req_if.sv
src/ffa_rsp_if.sv
src/ffa_cfg_if.sv
src/ffa_cell.sv
src/ffa_ctrl.sv
src/first_fit_block_allocator.sv
verif/tb.sv
